[sv/bfa_pkg.sv]
// shared constants, codes and types for the best-fit allocator
// no dependencies; imported by the cell, the top level and the checker
package bfa_pkg;

    localparam int NUM_BLOCKS_DEF = 16;
    localparam int SIZE_BITS_DEF  = 16;

    // fixed field widths
    localparam int INDEX_W = 4;
    localparam int LIMIT_W = 5;

    localparam logic [LIMIT_W-1:0] BLOCKS_IN_USE_RST = 5'd16;

    // operation codes carried in tuser
    localparam logic FUNC_LOAD    = 1'b0;
    localparam logic FUNC_REQUEST = 1'b1;

    // per-cell control from the sequencer
    typedef struct packed {
        logic load;
        logic commit;
    } bfa_cell_ctrl_t;

endpackage

[sv/bfa_cell.sv]
// one table entry of the allocator chain with its best-so-far stage
// depends on bfa_pkg
module bfa_cell
    import bfa_pkg::*;
#(
    parameter int SIZE_BITS = SIZE_BITS_DEF,
    parameter int IDX_W     = 4,
    parameter int INDEX     = 0
) (
    input  logic                 aclk,
    input  bfa_cell_ctrl_t       ctrl,
    input  logic [SIZE_BITS-1:0] load_data,
    input  logic [SIZE_BITS-1:0] req_size,
    input  logic [LIMIT_W-1:0]   limit,
    input  logic                 tok_in_have,
    input  logic [IDX_W-1:0]     tok_in_idx,
    input  logic [SIZE_BITS-1:0] tok_in_value,
    output logic                 tok_out_have,
    output logic [IDX_W-1:0]     tok_out_idx,
    output logic [SIZE_BITS-1:0] tok_out_value
);

    logic [SIZE_BITS-1:0] size_reg;
    logic                 have_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [SIZE_BITS-1:0] value_reg;
    logic                 take;

    // strictly smaller wins, so the lower index keeps ties
    assign take = (32'(limit) > INDEX) && (size_reg >= req_size) &&
                  (!tok_in_have || (size_reg < tok_in_value));

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            size_reg <= load_data;
        end else if (ctrl.commit) begin
            size_reg <= size_reg - req_size;
        end
        have_reg  <= tok_in_have | take;
        idx_reg   <= take ? IDX_W'(INDEX) : tok_in_idx;
        value_reg <= take ? size_reg : tok_in_value;
    end

    assign tok_out_have  = have_reg;
    assign tok_out_idx   = idx_reg;
    assign tok_out_value = value_reg;

endmodule

[sv/best_fit_allocator_unit.sv]
// best-fit allocator: a load word writes its table entry; a request word is accepted, then
// the best-so-far token ripples through NUM_BLOCKS cells, one cell per cycle, and a
// resolve state writes the result once the output register is free; no new input word
// is accepted until that result is written
// aresetn (synchronous, active low) clears the sequencer, the output valid and sets
// blocks_in_use to 16; table entries are undefined until loaded
module best_fit_allocator_unit
    import bfa_pkg::*;
#(
    parameter int  NUM_BLOCKS = NUM_BLOCKS_DEF,
    parameter int  SIZE_BITS  = SIZE_BITS_DEF,
    localparam int S_DATA_W   = ((INDEX_W + SIZE_BITS + 7) / 8) * 8,
    localparam int M_DATA_W   = ((INDEX_W + SIZE_BITS + 7) / 8) * 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    // configuration: blocks_in_use
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [LIMIT_W-1:0]  cfg_data,     // blocks_in_use
    // input words
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,      // block_index, size, zero pad
    input  logic [0:0]          s_tuser,      // func
    // result words
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,      // chosen_block, remaining, zero pad
    output logic [0:0]          m_tuser       // found
);

    localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CNT_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int PAD_W = M_DATA_W - INDEX_W - SIZE_BITS;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESOLVE
    } state_t;

    state_t               state_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [LIMIT_W-1:0]   limit_reg;
    logic [SIZE_BITS-1:0] req_reg;
    logic                 m_valid_reg;
    logic                 m_found_reg;
    logic [INDEX_W-1:0]   m_block_reg;
    logic [SIZE_BITS-1:0] m_remain_reg;

    // input word fields
    logic [INDEX_W-1:0]   in_index;
    logic [SIZE_BITS-1:0] in_size;
    logic                 in_fire;
    logic                 load_fire;
    logic                 resolve_fire;

    // token chain: entry 0 is the empty token fed to the first cell
    logic                 tok_have  [0:NUM_BLOCKS];
    logic [IDX_W-1:0]     tok_idx   [0:NUM_BLOCKS];
    logic [SIZE_BITS-1:0] tok_value [0:NUM_BLOCKS];
    bfa_cell_ctrl_t       cell_ctrl [0:NUM_BLOCKS-1];

    logic                 best_have;
    logic [IDX_W-1:0]     best_idx;
    logic [SIZE_BITS-1:0] best_value;

    assign in_index = s_tdata[INDEX_W-1:0];
    assign in_size  = s_tdata[INDEX_W+SIZE_BITS-1:INDEX_W];

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign load_fire = in_fire && (s_tuser[0] == FUNC_LOAD);

    // a finished scan leaves once the output register is free
    assign resolve_fire = (state_reg == ST_RESOLVE) && (!m_valid_reg || m_tready);

    assign tok_have[0]  = 1'b0;
    assign tok_idx[0]   = '0;
    assign tok_value[0] = '0;

    assign best_have  = tok_have[NUM_BLOCKS];
    assign best_idx   = tok_idx[NUM_BLOCKS];
    assign best_value = tok_value[NUM_BLOCKS];

    for (genvar j = 0; j < NUM_BLOCKS; j++) begin : g_cell
        // loads beyond the table match no cell and fall away
        assign cell_ctrl[j].load   = load_fire && (32'(in_index) == j);
        assign cell_ctrl[j].commit = resolve_fire && best_have && (32'(best_idx) == j);

        bfa_cell #(
            .SIZE_BITS (SIZE_BITS),
            .IDX_W     (IDX_W),
            .INDEX     (j)
        ) u_cell (
            .aclk          (aclk),
            .ctrl          (cell_ctrl[j]),
            .load_data     (in_size),
            .req_size      (req_reg),
            .limit         (limit_reg),
            .tok_in_have   (tok_have[j]),
            .tok_in_idx    (tok_idx[j]),
            .tok_in_value  (tok_value[j]),
            .tok_out_have  (tok_have[j+1]),
            .tok_out_idx   (tok_idx[j+1]),
            .tok_out_value (tok_value[j+1])
        );
    end

    // sequencer, config register and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            limit_reg   <= BLOCKS_IN_USE_RST;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                limit_reg <= cfg_data;
            end
            // a resolving scan refills the register in the same cycle
            if (m_valid_reg && m_tready && !resolve_fire) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_fire && (s_tuser[0] == FUNC_REQUEST)) begin
                        req_reg   <= in_size;
                        cnt_reg   <= '0;
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    // one cell settles per cycle
                    if (cnt_reg == CNT_W'(NUM_BLOCKS - 1)) begin
                        state_reg <= ST_RESOLVE;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_RESOLVE: begin
                    if (resolve_fire) begin
                        m_valid_reg  <= 1'b1;
                        m_found_reg  <= best_have;
                        m_block_reg  <= best_have ? INDEX_W'(best_idx) : '0;
                        m_remain_reg <= best_have ? (best_value - req_reg) : '0;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_found_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, m_remain_reg, m_block_reg};

endmodule

[sv/bfa_checker.sv]
// port-level checks for the best-fit allocator, bound to the top level
// depends on bfa_pkg and best_fit_allocator_unit
module bfa_checker
    import bfa_pkg::*;
#(
    parameter int M_DATA_W = 24
) (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic [0:0]          s_tuser,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic [0:0]          m_tuser
);

    // a stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // a not-found word carries zero index and zero remaining
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("not-found word has nonzero data");

    // the table is frozen while a request scans
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser[0] == FUNC_REQUEST) |=> !s_tready)
        else $error("input accepted during scan");

    // reset empties the output
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind best_fit_allocator_unit bfa_checker #(
    .M_DATA_W (M_DATA_W)
) u_bfa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

[bench/tb_top.sv]
// self-checking bench for best_fit_allocator_unit: loads and allocation requests
// on the stream ports, best-fit prediction kept in step, blocks_in_use phases
// depends on bfa_pkg and best_fit_allocator_unit
module tb_top;
    import bfa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DATA_W      = ((INDEX_W + SIZE_BITS_DEF + 7) / 8) * 8;
    localparam int STALL_LIMIT = 2000;   // cycles with no handshake at all
    localparam int SETTLE      = 2 * NUM_BLOCKS_DEF + 8;
    localparam int PHASE_WORDS = 183;

    typedef struct {
        logic                     func;
        logic [INDEX_W-1:0]       idx;
        logic [SIZE_BITS_DEF-1:0] size;
    } alloc_word_t;

    typedef struct {
        logic                     found;
        logic [INDEX_W-1:0]       chosen;
        logic [SIZE_BITS_DEF-1:0] remaining;
    } alloc_result_t;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [LIMIT_W-1:0] cfg_data = '0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata   = '0;   // block_index, size, zero pad
    logic [0:0]        s_tuser   = '0;   // func
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [DATA_W-1:0] m_tdata;          // chosen_block, remaining, zero pad
    logic [0:0]        m_tuser;          // found

    // words still to be sent, and allocation results still owed by the block
    alloc_word_t   pending_words[$];
    alloc_result_t alloc_expected[$];

    // shadow of the free-size table and the search count
    logic [SIZE_BITS_DEF-1:0] size_table [NUM_BLOCKS_DEF];
    logic [LIMIT_W-1:0]       blocks_in_use_shadow = BLOCKS_IN_USE_RST;

    bit word_taken    = 1'b0;  // set at the edge that accepted the presented word
    int mismatch_count = 0;
    int stall_cycles   = 0;
    int cycle_no       = 0;

    best_fit_allocator_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // a long window with no idling on either side, random 12% gaps elsewhere
    function automatic bit take_gap();
        if (cycle_no >= 3000 && cycle_no < 5500) begin
            return 1'b0;
        end
        return $urandom_range(99) < 12;
    endfunction

    // best fit over the shadow table: smallest entry not below the request,
    // lowest index on a tie; a load just overwrites its entry
    task automatic apply_alloc_word(input logic func, input logic [INDEX_W-1:0] idx,
                                    input logic [SIZE_BITS_DEF-1:0] sz);
        int            span;
        int            pick;
        bit            hit;
        alloc_result_t res;
        span = 0;
        pick = 0;
        hit  = 1'b0;
        if (func == FUNC_LOAD) begin
            size_table[idx] = sz;
        end else begin
            // counts above the table size saturate
            span = (blocks_in_use_shadow > NUM_BLOCKS_DEF) ? NUM_BLOCKS_DEF
                                                           : int'(blocks_in_use_shadow);
            for (int j = 0; j < span; j++) begin
                if (size_table[j] >= sz && (!hit || size_table[j] < size_table[pick])) begin
                    pick = j;
                    hit  = 1'b1;
                end
            end
            res.found     = hit;
            res.chosen    = '0;
            res.remaining = '0;
            if (hit) begin
                size_table[pick] = size_table[pick] - sz;
                res.chosen       = pick[INDEX_W-1:0];
                res.remaining    = size_table[pick];
            end
            alloc_expected.push_back(res);
        end
    endtask

    // sender: next word goes out at the falling edge once the last one was taken
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || word_taken) begin
            word_taken = 1'b0;
            if (pending_words.size() > 0 && !take_gap()) begin
                alloc_word_t w;
                w = pending_words.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= w.func;
                s_tdata  <= {{(DATA_W - INDEX_W - SIZE_BITS_DEF){1'b0}}, w.size, w.idx};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver back-pressure
    always @(negedge aclk) begin
        m_tready <= !take_gap();
    end

    // rising edge: predict accepted words, track the register, check results
    always @(posedge aclk) begin
        bit moved;
        alloc_result_t want;
        moved = 1'b0;
        cycle_no++;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                blocks_in_use_shadow = cfg_data;
                moved = 1'b1;
            end
            if (s_tvalid && s_tready) begin
                apply_alloc_word(s_tuser[0], s_tdata[INDEX_W-1:0],
                                 s_tdata[INDEX_W +: SIZE_BITS_DEF]);
                word_taken = 1'b1;
                moved = 1'b1;
            end
            if (m_tvalid && m_tready) begin
                moved = 1'b1;
                if (alloc_expected.size() == 0) begin
                    $error("result word with no request outstanding: found %0d block %0d",
                           m_tuser[0], m_tdata[INDEX_W-1:0]);
                    mismatch_count++;
                end else begin
                    want = alloc_expected.pop_front();
                    if (m_tuser[0] !== want.found) begin
                        $error("found: expected %0d, actual %0d", want.found, m_tuser[0]);
                        mismatch_count++;
                    end
                    if (m_tdata[INDEX_W-1:0] !== want.chosen) begin
                        $error("chosen_block: expected %0d, actual %0d",
                               want.chosen, m_tdata[INDEX_W-1:0]);
                        mismatch_count++;
                    end
                    if (m_tdata[INDEX_W +: SIZE_BITS_DEF] !== want.remaining) begin
                        $error("remaining: expected %0d, actual %0d",
                               want.remaining, m_tdata[INDEX_W +: SIZE_BITS_DEF]);
                        mismatch_count++;
                    end
                end
            end
        end
        stall_cycles = moved ? 0 : stall_cycles + 1;
    end

    // watchdog on a hung handshake
    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("[best_fit_allocator_unit] ERROR");
        $finish;
    end

    task automatic push_word(input logic func, input int idx, input int sz);
        alloc_word_t w;
        w.func = func;
        w.idx  = idx[INDEX_W-1:0];
        w.size = sz[SIZE_BITS_DEF-1:0];
        pending_words.push_back(w);
    endtask

    // block must be idle before the register moves: all sent, all results in,
    // plus the scan time a trailing load or request may still need
    task automatic drain_block();
        do @(posedge aclk);
        while (pending_words.size() != 0 || s_tvalid || alloc_expected.size() != 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_blocks_in_use(input logic [LIMIT_W-1:0] v);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk);
        while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // random words: a small pool of sizes per phase so exact fits and ties recur
    task automatic queue_random_phase(input int count);
        int pool [6];
        int sz;
        int r;
        foreach (pool[k]) begin
            pool[k] = ($urandom_range(1) == 1) ? $urandom_range(65535) : $urandom_range(300);
        end
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(99);
            case ($urandom_range(9))
                0, 1, 2, 3: sz = pool[$urandom_range(5)];
                4, 5:       sz = $urandom_range(65535);
                6, 7:       sz = $urandom_range(255);
                8:          sz = 0;
                default:    sz = 65535;
            endcase
            push_word((r < 45) ? FUNC_LOAD : FUNC_REQUEST, $urandom_range(15), sz);
        end
    endtask

    initial begin
        logic [LIMIT_W-1:0] setting;
        // directed table: zero, full scale, a tie at 100, alternating bit patterns
        static int load_sizes [NUM_BLOCKS_DEF] = '{500, 0, 65535, 100, 7000, 40000, 250, 1,
                                                   32768, 100, 12345, 65534, 2, 800,
                                                   21845, 43690};
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        // every entry loaded first, so no scan ever reads an unwritten entry
        for (int i = 0; i < NUM_BLOCKS_DEF; i++) begin
            push_word(FUNC_LOAD, i, load_sizes[i]);
        end
        push_word(FUNC_REQUEST, 0, 0);          // zero request, exact fit on zero
        push_word(FUNC_REQUEST, 5, 100);        // tie, lowest index wins
        push_word(FUNC_REQUEST, 15, 100);       // second of the tie
        push_word(FUNC_REQUEST, 0, 65535);      // full scale exact fit
        push_word(FUNC_REQUEST, 0, 65535);      // nothing large enough left
        push_word(FUNC_REQUEST, 10, 3);         // plain best fit with remainder
        drain_block();

        // empty search
        write_blocks_in_use('0);
        push_word(FUNC_REQUEST, 0, 0);
        drain_block();

        // count beyond the table saturates
        write_blocks_in_use(5'd31);
        push_word(FUNC_REQUEST, 0, 1);
        drain_block();

        for (int p = 0; p < 10; p++) begin
            case (p)
                0:       setting = 5'd1;
                1:       setting = 5'd16;
                2:       setting = 5'd31;
                3:       setting = 5'd0;
                4:       setting = 5'd17;
                default: setting = $urandom_range(31);
            endcase
            write_blocks_in_use(setting);
            queue_random_phase(PHASE_WORDS);
            drain_block();
        end

        if (mismatch_count == 0) begin
            $display("[best_fit_allocator_unit] OK");
        end else begin
            $display("[best_fit_allocator_unit] ERROR");
        end
        $finish;
    end

endmodule
